@@ design/relo_pkg.sv @@
package relo_pkg;

	// Default configuration of the ring.
	localparam int RING_ENTRIES_DEF = 16;
	localparam int LENGTH_BITS_DEF  = 20;

	// Request modes.
	localparam logic [1:0] MODE_APPEND   = 2'd0;
	localparam logic [1:0] MODE_LOCATE   = 2'd1;
	localparam logic [1:0] MODE_POSITION = 2'd2;

	localparam logic [23:0] MAX24 = 24'hFFFFFF;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] entry_handle;
		logic [19:0] entry_size;
		logic [23:0] locate_offset;
		logic [3:0]  entry_position;
		logic [19:0] record_offset;
	} req_t;

	typedef struct packed {
		logic        status;
		logic        evicted;
		logic [31:0] handle_out;
		logic [3:0]  slot_out;
		logic [19:0] byte_in_entry;
		logic [23:0] absolute_offset;
		logic [4:0]  record_count;
		logic [23:0] total_bytes;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_APP_RD,
		ST_APP_WR,
		ST_WALK,
		ST_REJECT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic app_read;
		logic app_commit;
		logic walk;
		logic reject;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_append;
		logic walk_ok;
		logic walk_fin;
	} ctl_sts_t;

	// Clamp a byte count to the 24-bit result range.
	function automatic logic [23:0] sat24(input logic [63:0] v);
		logic [23:0] r;
		r = (v > 64'(MAX24)) ? MAX24 : v[23:0];
		return r;
	endfunction

endpackage

@@ design/relo_ctrl.sv @@
module relo_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  relo_pkg::ctl_sts_t  sts,
	output logic                busy,
	output relo_pkg::ctl_cmd_t  cmd
);

	relo_pkg::state_t state_q;
	relo_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= relo_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			relo_pkg::ST_IDLE: begin
				if (start) begin
					state_d = relo_pkg::ST_DISPATCH;
				end
			end
			relo_pkg::ST_DISPATCH: begin
				priority if (sts.is_append) begin
					state_d = relo_pkg::ST_APP_RD;
				end else if (sts.walk_ok) begin
					state_d = relo_pkg::ST_WALK;
				end else begin
					state_d = relo_pkg::ST_REJECT;
				end
			end
			relo_pkg::ST_APP_RD: begin
				state_d = relo_pkg::ST_APP_WR;
			end
			relo_pkg::ST_APP_WR: begin
				state_d = relo_pkg::ST_IDLE;
			end
			relo_pkg::ST_WALK: begin
				if (sts.walk_fin) begin
					state_d = relo_pkg::ST_IDLE;
				end
			end
			relo_pkg::ST_REJECT: begin
				state_d = relo_pkg::ST_IDLE;
			end
			default: begin
				state_d = relo_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy           = (state_q != relo_pkg::ST_IDLE);
		cmd.capture    = (state_q == relo_pkg::ST_IDLE) && start;
		cmd.app_read   = (state_q == relo_pkg::ST_APP_RD);
		cmd.app_commit = (state_q == relo_pkg::ST_APP_WR);
		cmd.walk       = (state_q == relo_pkg::ST_WALK);
		cmd.reject     = (state_q == relo_pkg::ST_REJECT);
	end

endmodule

@@ design/relo_dpath.sv @@
module relo_dpath #(
	parameter int RING_ENTRIES = relo_pkg::RING_ENTRIES_DEF,
	parameter int LENGTH_BITS  = relo_pkg::LENGTH_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  relo_pkg::req_t      request,
	input  relo_pkg::ctl_cmd_t  cmd,
	output relo_pkg::ctl_sts_t  sts,
	output logic                done,
	output relo_pkg::res_t      result
);

	localparam int SLOT_W = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(RING_ENTRIES + 1);
	localparam int SUM_W  = LENGTH_BITS + CNT_W;
	localparam int ACC_W  = (SUM_W > 24) ? SUM_W : 24;
	localparam int ABS_W  = ACC_W + 1;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_ENTRIES - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(RING_ENTRIES);

	// Record storage, one read port with registered data, one write port.
	logic [31:0]            hdl_mem [RING_ENTRIES];
	logic [LENGTH_BITS-1:0] len_mem [RING_ENTRIES];

	relo_pkg::req_t         req_q;
	logic [SLOT_W-1:0]      write_q;
	logic [SLOT_W-1:0]      oldest_q;
	logic [CNT_W-1:0]       count_q;
	logic [ACC_W-1:0]       total_q;
	logic [SLOT_W-1:0]      walk_slot_q;
	logic [CNT_W-1:0]       walk_idx_q;
	logic [ACC_W-1:0]       acc_q;
	logic                   done_q;
	relo_pkg::res_t         res_q;

	logic                   rdv_s1;
	logic [31:0]            rd_hdl_s1;
	logic [LENGTH_BITS-1:0] rd_len_s1;
	logic [SLOT_W-1:0]      rd_slot_s1;
	logic [CNT_W-1:0]       rd_idx_s1;

	logic                   ring_full;
	logic [SLOT_W-1:0]      wr_nxt;
	logic [SLOT_W-1:0]      walk_nxt;
	logic [LENGTH_BITS-1:0] new_len;
	logic                   is_locate;
	logic                   is_position;
	logic                   pos_lt_cnt;
	logic [CNT_W-1:0]       walk_limit;
	logic                   issue;
	logic                   rd_en;
	logic [SLOT_W-1:0]      rd_addr;
	logic [ACC_W-1:0]       len_ext;
	logic                   hit;
	logic [CNT_W-1:0]       idx_inc;
	logic                   last;
	logic                   at_pos;
	logic                   off_ok;
	logic [ABS_W-1:0]       abs_sum;
	logic                   walk_fin;
	logic [ACC_W-1:0]       total_app;
	logic [CNT_W-1:0]       count_app;
	logic                   load_res;
	relo_pkg::res_t         res_d;

	always_comb begin
		ring_full   = (count_q == FULL_CNT);
		wr_nxt      = (write_q == LAST_SLOT) ? '0 : SLOT_W'(write_q + 1'b1);
		walk_nxt    = (walk_slot_q == LAST_SLOT) ? '0 : SLOT_W'(walk_slot_q + 1'b1);
		new_len     = LENGTH_BITS'(req_q.entry_size);
		is_locate   = (req_q.mode == relo_pkg::MODE_LOCATE);
		is_position = (req_q.mode == relo_pkg::MODE_POSITION);
		pos_lt_cnt  = (8'(req_q.entry_position) < 8'(count_q));
		// A position walk covers the records before the index and the indexed one.
		walk_limit  = is_locate ? count_q
		                        : CNT_W'(CNT_W'(req_q.entry_position) + 1'b1);
		issue       = cmd.walk && (walk_idx_q < walk_limit);
		rd_en       = cmd.app_read || issue;
		rd_addr     = cmd.app_read ? write_q : walk_slot_q;

		len_ext     = ACC_W'(rd_len_s1);
		hit         = (len_ext > acc_q);
		idx_inc     = CNT_W'(rd_idx_s1 + 1'b1);
		last        = (idx_inc == count_q);
		at_pos      = (rd_idx_s1 == CNT_W'(req_q.entry_position));
		off_ok      = (32'(req_q.record_offset) < 32'(rd_len_s1));
		abs_sum     = ABS_W'(acc_q) + ABS_W'(req_q.record_offset);
		walk_fin    = cmd.walk && rdv_s1 && (is_locate ? (hit || last) : at_pos);

		total_app   = ACC_W'(total_q + ACC_W'(new_len)
		                     - (ring_full ? len_ext : ACC_W'(0)));
		count_app   = ring_full ? count_q : CNT_W'(count_q + 1'b1);
	end

	always_comb begin
		sts.is_append = (req_q.mode == relo_pkg::MODE_APPEND);
		sts.walk_ok   = (is_locate && (count_q != '0)) || (is_position && pos_lt_cnt);
		sts.walk_fin  = walk_fin;
	end

	always_comb begin
		res_d              = '0;
		res_d.record_count = 5'(count_q);
		res_d.total_bytes  = relo_pkg::sat24(64'(total_q));
		priority if (cmd.app_commit) begin
			res_d.evicted      = ring_full;
			res_d.handle_out   = ring_full ? rd_hdl_s1 : 32'd0;
			res_d.record_count = 5'(count_app);
			res_d.total_bytes  = relo_pkg::sat24(64'(total_app));
		end else if (cmd.reject) begin
			res_d.status = 1'b1;
		end else if (is_locate) begin
			if (hit) begin
				res_d.handle_out    = rd_hdl_s1;
				res_d.slot_out      = 4'(rd_slot_s1);
				res_d.byte_in_entry = acc_q[19:0];
			end else begin
				res_d.status = 1'b1;
			end
		end else begin
			if (off_ok) begin
				res_d.absolute_offset = relo_pkg::sat24(64'(abs_sum));
			end else begin
				res_d.status = 1'b1;
			end
		end
		load_res = cmd.app_commit || cmd.reject || walk_fin;
	end

	always_ff @(posedge clk) begin
		if (cmd.app_commit) begin
			hdl_mem[write_q] <= req_q.entry_handle;
			len_mem[write_q] <= new_len;
		end
		if (rd_en) begin
			rd_hdl_s1 <= hdl_mem[rd_addr];
			rd_len_s1 <= len_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= request;
			acc_q <= (request.mode == relo_pkg::MODE_LOCATE) ?
			         ACC_W'(request.locate_offset) : '0;
		end else if (cmd.walk && rdv_s1 && !walk_fin) begin
			acc_q <= is_locate ? ACC_W'(acc_q - len_ext) : ACC_W'(acc_q + len_ext);
		end
		if (issue) begin
			rd_slot_s1 <= walk_slot_q;
			rd_idx_s1  <= walk_idx_q;
		end
		if (load_res) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_q     <= '0;
			oldest_q    <= '0;
			count_q     <= '0;
			total_q     <= '0;
			walk_slot_q <= '0;
			walk_idx_q  <= '0;
			rdv_s1      <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= load_res;
			rdv_s1 <= issue;
			if (cmd.capture) begin
				walk_slot_q <= oldest_q;
				walk_idx_q  <= '0;
			end else if (issue) begin
				walk_slot_q <= walk_nxt;
				walk_idx_q  <= CNT_W'(walk_idx_q + 1'b1);
			end
			if (cmd.app_commit) begin
				write_q <= wr_nxt;
				count_q <= count_app;
				total_q <= total_app;
				if (ring_full) begin
					oldest_q <= wr_nxt;
				end
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("record count above ring size");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		!ring_full |-> (((write_q >= oldest_q) ? (int'(write_q) - int'(oldest_q))
		: (int'(write_q) + RING_ENTRIES - int'(oldest_q))) == int'(count_q)))
		else $error("write and oldest slots disagree with record count");

	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		ring_full |-> (write_q == oldest_q))
		else $error("full ring with write slot apart from oldest slot");

	a_empty_total: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (total_q == '0))
		else $error("empty ring holds bytes");

	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("results on consecutive cycles");
`endif

endmodule

@@ design/ring_entry_offset_locator.sv @@
// Ring of write records, oldest to newest, that overwrites the oldest record when full.
// A request is taken at a rising clock edge where start is high and busy is low; its
// fields travel in the request struct. Mode append stores a record and, when the ring
// is full, evicts the oldest and returns its handle. Mode locate maps a byte offset in
// the records laid end to end to the holding record's handle, slot and byte. Mode
// position turns a record index and an in-record offset into an absolute offset.
// Every result carries the record count and total bytes after the request.
// Each result is marked by done for exactly one cycle and then stays on the result
// struct until the next; the receiver cannot hold it off, and busy drops in that same
// cycle, so the next request may be taken while the result is shown.
// An append passes dispatch, a read of the write slot and a write; a rejected
// request (unused mode, empty ring on locate, index past the count) passes dispatch
// and a reject state; a locate or position walks the records from the oldest up to
// the one it ends on. A request sent back to back is taken at the edge that ends
// the done cycle of the one before; none is taken while busy is high.
// The walk reads one stored record per cycle through the single registered read port
// of the record memory.
// Reset clears the slot pointers, record count and byte total, so the ring starts
// empty; record storage is not cleared, since only data from written slots is used.
module ring_entry_offset_locator #(
	parameter int RING_ENTRIES = relo_pkg::RING_ENTRIES_DEF,
	parameter int LENGTH_BITS  = relo_pkg::LENGTH_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  relo_pkg::req_t  request,
	output logic            busy,
	output logic            done,
	output relo_pkg::res_t  result
);

	// Command and status between the sequencer and the record datapath.
	relo_pkg::ctl_cmd_t cmd;
	relo_pkg::ctl_sts_t sts;

	// The controller steps each request through dispatch, the append read and
	// write, the record walk, or a rejection.
	relo_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	// The datapath holds the record memory, the ring pointers, the running byte
	// total and the walk accumulator, and registers each result.
	relo_dpath #(
		.RING_ENTRIES (RING_ENTRIES),
		.LENGTH_BITS  (LENGTH_BITS)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.done    (done),
		.result  (result)
	);

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	// The fourth mode value has no operation; the block must reject it.
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int RING_DEPTH    = relo_pkg::RING_ENTRIES_DEF;
	localparam int RANDOM_ITEMS  = 535;
	// The slowest request ends on the sixteenth record.
	localparam int SETTLE_CYCLES = 40;
	// The limit lies well above what a correct run needs, even with every gap at its longest.
	localparam int CYCLE_LIMIT   = 200000;

	// The scoreboard keeps its own copy of the ring. Each accepted request is
	// applied to that copy at once, and the result it should produce is queued,
	// so results come back in the order their requests were taken.
	class record_ring_scoreboard;
		logic [31:0] handles [0:RING_DEPTH-1];
		logic [19:0] lengths [0:RING_DEPTH-1];
		logic [3:0]  write_slot;
		logic [3:0]  oldest_slot;
		bit          ring_full;
		relo_pkg::res_t pending_results [$];
		int unsigned mismatches;

		function new();
			write_slot  = '0;
			oldest_slot = '0;
			ring_full   = 1'b0;
			mismatches  = 0;
		endfunction

		function int held_count();
			if (ring_full) begin
				return RING_DEPTH;
			end
			return int'(4'(write_slot - oldest_slot));
		endfunction

		function logic [3:0] slot_at(int idx);
			return oldest_slot + 4'(idx);
		endfunction

		// Sum of the lengths of the first count records, oldest first.
		function longint bytes_before(int count);
			longint sum;
			sum = 0;
			for (int i = 0; i < count; i++) begin
				sum += longint'(lengths[slot_at(i)]);
			end
			return sum;
		endfunction

		function logic [23:0] clamp_bytes(longint v);
			return (v > longint'(relo_pkg::MAX24)) ? relo_pkg::MAX24 : v[23:0];
		endfunction

		function relo_pkg::res_t predict_result(relo_pkg::req_t r);
			relo_pkg::res_t res;
			logic [3:0] w;
			longint rem;
			int     n;
			int     i;
			bit     found;
			res = '0;
			n = held_count();
			case (r.mode)
				relo_pkg::MODE_APPEND: begin
					w = write_slot;
					if (ring_full) begin
						res.evicted    = 1'b1;
						res.handle_out = handles[w];
					end
					handles[w] = r.entry_handle;
					lengths[w] = r.entry_size;
					write_slot = w + 4'd1;
					if (ring_full) begin
						oldest_slot = write_slot;
					end else if (write_slot == oldest_slot) begin
						ring_full = 1'b1;
					end
				end
				relo_pkg::MODE_LOCATE: begin
					// Zero-length records can never be larger than what is left, so
					// the walk passes over them.
					rem = longint'(r.locate_offset);
					found = 1'b0;
					for (i = 0; i < n && !found; i++) begin
						w = slot_at(i);
						if (longint'(lengths[w]) > rem) begin
							found             = 1'b1;
							res.handle_out    = handles[w];
							res.slot_out      = w;
							res.byte_in_entry = rem[19:0];
						end else begin
							rem -= longint'(lengths[w]);
						end
					end
					res.status = !found;
				end
				relo_pkg::MODE_POSITION: begin
					if (int'(r.entry_position) >= n) begin
						res.status = 1'b1;
					end else if (r.record_offset >= lengths[slot_at(r.entry_position)]) begin
						res.status = 1'b1;
					end else begin
						res.absolute_offset = clamp_bytes(bytes_before(r.entry_position)
							+ longint'(r.record_offset));
					end
				end
				default: begin
					res.status = 1'b1;
				end
			endcase
			res.record_count = 5'(held_count());
			res.total_bytes  = clamp_bytes(bytes_before(held_count()));
			return res;
		endfunction

		function void note_request(relo_pkg::req_t r);
			pending_results.push_back(predict_result(r));
		endfunction

		function int pending_count();
			return pending_results.size();
		endfunction

		function void compare_field(string field_name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h",
					$time, field_name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(relo_pkg::res_t got);
			relo_pkg::res_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: result with no request outstanding, expected none, actual %h",
					$time, got);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("evicted", 32'(want.evicted), 32'(got.evicted));
			compare_field("handle_out", want.handle_out, got.handle_out);
			compare_field("slot_out", 32'(want.slot_out), 32'(got.slot_out));
			compare_field("byte_in_entry", 32'(want.byte_in_entry), 32'(got.byte_in_entry));
			compare_field("absolute_offset", 32'(want.absolute_offset),
				32'(got.absolute_offset));
			compare_field("record_count", 32'(want.record_count), 32'(got.record_count));
			compare_field("total_bytes", 32'(want.total_bytes), 32'(got.total_bytes));
		endfunction
	endclass

	// Every input has a known value from time zero, and reset is asserted at once.
	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	relo_pkg::req_t request = '0;
	logic busy;
	logic done;
	relo_pkg::res_t result;

	int unsigned cycle_count = 0;
	event request_taken;
	record_ring_scoreboard sb = new();

	ring_entry_offset_locator DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Outputs are sampled at the rising edge, before the block updates them.
	// A result shown in the same cycle as a new request is taken belongs to an
	// earlier request, so it is checked before the new request is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				sb.check_result(result);
			end
			if (start && !busy) begin
				sb.note_request(request);
				-> request_taken;
			end
		end
	end

	// A hung block must not stall the run forever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, sb.pending_count());
			$display("ring_entry_offset_locator verification failed");
			$finish;
		end
	end

	function automatic relo_pkg::req_t make_request(logic [1:0] mode, logic [31:0] handle,
		logic [19:0] size, logic [23:0] offset, logic [3:0] pos, logic [19:0] off_in);
		relo_pkg::req_t r;
		r.mode            = mode;
		r.entry_handle    = handle;
		r.entry_size      = size;
		r.locate_offset   = offset;
		r.entry_position  = pos;
		r.record_offset   = off_in;
		return r;
	endfunction

	// Random requests are shaped from the current ring contents: most locates
	// land inside the held bytes or right on a record boundary, and most
	// position requests name a held record and an offset inside it. The rest
	// are out of range on purpose. Fields that the mode ignores stay random.
	function automatic relo_pkg::req_t random_request();
		relo_pkg::req_t r;
		int     pick;
		int     n;
		int     k;
		longint total;
		longint edge_offset;
		logic [19:0] len;
		r.mode            = MODE_UNUSED;
		r.entry_handle    = $urandom();
		r.entry_size      = 20'($urandom());
		r.locate_offset   = 24'($urandom());
		r.entry_position  = 4'($urandom());
		r.record_offset   = 20'($urandom());
		n = sb.held_count();
		total = sb.bytes_before(n);
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			r.mode = relo_pkg::MODE_APPEND;
			case ($urandom_range(0, 9))
				0, 1: r.entry_size = '0;
				2, 3, 4, 5: r.entry_size = 20'($urandom_range(1, 64));
				9: r.entry_size = '1;
				default: ;
			endcase
		end else if (pick < 65) begin
			r.mode = relo_pkg::MODE_LOCATE;
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				r.locate_offset = 24'($urandom_range(0, 32'(total)));
			end else if (pick < 8 && n > 0) begin
				// Hit the first byte of a record, or the last byte before it.
				k = $urandom_range(0, n - 1);
				edge_offset = sb.bytes_before(k) - longint'($urandom_range(0, 1));
				r.locate_offset = edge_offset[23:0];
			end else if (pick < 9) begin
				r.locate_offset = total[23:0];
			end
		end else if (pick < 95) begin
			r.mode = relo_pkg::MODE_POSITION;
			if (n > 0 && $urandom_range(0, 99) < 85) begin
				r.entry_position = 4'($urandom_range(0, n - 1));
			end
			if (int'(r.entry_position) < n) begin
				len = sb.lengths[sb.slot_at(r.entry_position)];
				pick = $urandom_range(0, 99);
				if (pick < 70 && len != '0) begin
					r.record_offset = 20'($urandom_range(0, 32'(len) - 1));
				end else if (pick < 85) begin
					r.record_offset = len;
				end
			end
		end
		return r;
	endfunction

	// Each call starts at a falling edge and returns at the falling edge after
	// the request was taken. About one request in four is preceded by a random
	// gap, so gaps land at every point of the block's walk.
	task automatic send_request(input relo_pkg::req_t r, input bit may_idle);
		int gap;
		if (may_idle && $urandom_range(0, 99) < 24) begin
			gap = $urandom_range(1, 20);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start   <= 1'b1;
		request <= r;
		@(request_taken);
		@(negedge clk);
	endtask

	// Hold off until every outstanding result has come back.
	task automatic drain_results();
		start <= 1'b0;
		do begin
			@(negedge clk);
		end while (sb.pending_count() != 0);
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part. The ring starts empty, so locate and position must be
		// rejected, as must a request in the unused mode. Then a zero-length record,
		// a full-length record and a short one are appended and probed at their edges.
		send_request(make_request(relo_pkg::MODE_LOCATE, '0, '0, '0, '0, '0), 1'b1);
		send_request(make_request(relo_pkg::MODE_POSITION, '0, '0, '0, '0, '0), 1'b1);
		send_request('1, 1'b1);
		send_request(make_request(relo_pkg::MODE_APPEND, '1, '0, '0, '0, '0), 1'b1);
		send_request(make_request(relo_pkg::MODE_APPEND, '0, '1, '0, '0, '0), 1'b1);
		send_request(make_request(relo_pkg::MODE_APPEND, 32'hA5A5_5A5A, 20'h10,
			'0, '0, '0), 1'b1);
		// Offset zero skips the zero-length record and lands in the second one.
		send_request(make_request(relo_pkg::MODE_LOCATE, '0, '0, 24'h0, '0, '0), 1'b1);
		send_request(make_request(relo_pkg::MODE_LOCATE, '0, '0, 24'h0F_FFFF, '0, '0), 1'b1);
		send_request(make_request(relo_pkg::MODE_LOCATE, '0, '0, 24'h10_000E, '0, '0), 1'b1);
		// An offset equal to the total, and the largest offset, are both past the end.
		send_request(make_request(relo_pkg::MODE_LOCATE, '0, '0, 24'h10_000F, '0, '0), 1'b1);
		send_request(make_request(relo_pkg::MODE_LOCATE, '0, '0, '1, '0, '0), 1'b1);
		// A zero-length record holds no offset at all.
		send_request(make_request(relo_pkg::MODE_POSITION, '0, '0, '0, 4'd0, 20'h0), 1'b1);
		send_request(make_request(relo_pkg::MODE_POSITION, '0, '0, '0, 4'd1, 20'hF_FFFE),
			1'b1);
		send_request(make_request(relo_pkg::MODE_POSITION, '0, '0, '0, 4'd1, '1), 1'b1);
		send_request(make_request(relo_pkg::MODE_POSITION, '0, '0, '0, 4'd2, 20'hF), 1'b1);
		send_request(make_request(relo_pkg::MODE_POSITION, '0, '0, '0, 4'd3, 20'h0), 1'b1);
		send_request(make_request(relo_pkg::MODE_POSITION, '0, '0, '0, '1, 20'h0), 1'b1);
		drain_results();

		// Random part. The ring fills once it holds sixteen records and evicts from
		// then on. One stretch runs back to back with no gaps, and once the
		// sender waits for every result before going on.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 150) begin
				drain_results();
			end
			send_request(random_request(), !(i >= 250 && i < 400));
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.mismatches == 0) begin
			$display("ring_entry_offset_locator verification clean");
		end else begin
			$display("ring_entry_offset_locator verification failed");
		end
		$finish;
	end

endmodule
